// ===== sv/ipv4_forward_filter_core_defines.svh =====
// Assertion macros for the verification files of the forwarding filter.
`ifndef IPV4_FORWARD_FILTER_CORE_DEFINES_SVH
`define IPV4_FORWARD_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while the reset input is low.
`define IPV4FF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the reset input is low.
`define IPV4FF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ipv4ff_pkg.sv =====
// Shared types and constants of the IPv4 forwarding filter.
`timescale 1ns / 1ps
`default_nettype none

package ipv4ff_pkg;

    localparam int TABLE_ENTRIES = 64;

    localparam int CMD_W     = 2;
    localparam int VERDICT_W = 2;

    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [VERDICT_W-1:0] VERDICT_PASS  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_DROP  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_TX    = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_TABLE = 2'd3;

    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [15:0] MIN_FRAME_BYTES = 16'd34;

    // Input transaction payload, last field in the lowest bits.
    typedef struct packed {
        logic [1:0]  pad;
        logic [31:0] ip_dest_address;
        logic [63:0] ip_bytes_8_15;
        logic [63:0] ip_bytes_0_7;
        logic [15:0] ether_type;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [15:0] frame_length;
        logic [31:0] entry_address;
        logic [5:0]  slot;
    } s_data_t;

    // Result transaction payload, last field in the lowest bits.
    typedef struct packed {
        logic [15:0] out_checksum;
        logic [7:0]  out_ttl;
        logic [47:0] out_src_mac;
        logic [47:0] out_dst_mac;
    } m_data_t;

    // Blacklist write request.
    typedef struct packed {
        logic        en;
        logic        set;
        logic [5:0]  slot;
        logic [31:0] address;
    } tbl_wr_t;

endpackage

`default_nettype wire

// ===== sv/ipv4_forward_filter_core.sv =====
// Top level of the IPv4 forwarding filter with destination blacklist.
//
// Each input transaction carries either a frame header (tuser = 0) or a
// blacklist command (tuser = 1 sets a slot, tuser = 2 clears it). Every input
// transaction yields exactly one result transaction, whose tuser is the
// verdict: pass, drop, transmit or table updated. Transmitted headers have
// the MACs swapped, the TTL decremented and the header checksum recomputed.
// The design has an input register and a result register with one level of
// logic between them. An accepted transaction waits in the input register
// until the result register is free or being taken, then moves on into it.
// One transaction per cycle is sustained while the receiver takes results.
// The blacklist match compares the destination against all slots at once,
// and table commands take effect for every frame that follows them.
// When the receiver stalls, the result register holds its transaction and
// the input register can still take one more; after that, s_axis_tready
// falls until the result is taken. Reset empties the blacklist and both
// register stages; the block accepts input as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_forward_filter_core (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_axis_tvalid,
    output logic                     s_axis_tready,
    // slot, entry_address, frame_length, dst_mac, src_mac, ether_type,
    // ip_bytes_0_7, ip_bytes_8_15, ip_dest_address, two zero bits
    input  wire ipv4ff_pkg::s_data_t s_axis_tdata,
    // command
    input  wire [1:0]                s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    // out_dst_mac, out_src_mac, out_ttl, out_checksum
    output ipv4ff_pkg::m_data_t      m_axis_tdata,
    // verdict
    output logic [1:0]               m_axis_tuser
);
    import ipv4ff_pkg::*;

    logic                 s1_valid_reg;
    logic [CMD_W-1:0]     s1_cmd_reg;
    s_data_t              s1_data_reg;
    logic                 s1_adv;

    logic                 m_valid_reg;
    logic [VERDICT_W-1:0] m_user_reg;
    m_data_t              m_data_reg;
    logic [VERDICT_W-1:0] m_user_next;
    m_data_t              m_data_next;

    tbl_wr_t              tbl_wr;
    logic                 tbl_hit;

    logic [7:0]           ttl;
    logic [7:0]           new_ttl;
    logic [19:0]          sum;
    logic [16:0]          fold1;
    logic [15:0]          fold2;
    logic                 non_ipv4;

    assign s1_adv        = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            s1_cmd_reg  <= s_axis_tuser;
            s1_data_reg <= s_axis_tdata;
        end
    end

    always_comb begin
        tbl_wr.en      = s1_valid_reg && s1_adv &&
                         ((s1_cmd_reg == CMD_SET) || (s1_cmd_reg == CMD_CLEAR));
        tbl_wr.set     = (s1_cmd_reg == CMD_SET);
        tbl_wr.slot    = s1_data_reg.slot;
        tbl_wr.address = s1_data_reg.entry_address;
    end

    ipv4ff_blacklist u_blacklist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr          (tbl_wr),
        .lookup_addr (s1_data_reg.ip_dest_address),
        .hit         (tbl_hit)
    );

    assign ttl      = s1_data_reg.ip_bytes_8_15[63:56];
    assign new_ttl  = ttl - 8'd1;
    assign non_ipv4 = (s1_data_reg.frame_length < MIN_FRAME_BYTES) ||
                      (s1_data_reg.ether_type != ETHERTYPE_IPV4);

    // The checksum field itself counts as zero and is left out of the sum.
    always_comb begin
        sum = 20'(s1_data_reg.ip_bytes_0_7[63:48]) +
              20'(s1_data_reg.ip_bytes_0_7[47:32]) +
              20'(s1_data_reg.ip_bytes_0_7[31:16]) +
              20'(s1_data_reg.ip_bytes_0_7[15:0]) +
              20'({new_ttl, s1_data_reg.ip_bytes_8_15[55:48]}) +
              20'(s1_data_reg.ip_bytes_8_15[31:16]) +
              20'(s1_data_reg.ip_bytes_8_15[15:0]) +
              20'(s1_data_reg.ip_dest_address[31:16]) +
              20'(s1_data_reg.ip_dest_address[15:0]);
        fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
        fold2 = fold1[15:0] + 16'(fold1[16]);
    end

    always_comb begin
        m_data_next.out_dst_mac  = s1_data_reg.dst_mac;
        m_data_next.out_src_mac  = s1_data_reg.src_mac;
        m_data_next.out_ttl      = ttl;
        m_data_next.out_checksum = s1_data_reg.ip_bytes_8_15[47:32];
        m_user_next              = VERDICT_PASS;
        unique case (s1_cmd_reg) inside
            CMD_FRAME: begin
                if (non_ipv4) begin
                    m_user_next = VERDICT_PASS;
                end else if (tbl_hit || (ttl <= 8'd1)) begin
                    m_user_next = VERDICT_DROP;
                end else begin
                    m_user_next              = VERDICT_TX;
                    m_data_next.out_dst_mac  = s1_data_reg.src_mac;
                    m_data_next.out_src_mac  = s1_data_reg.dst_mac;
                    m_data_next.out_ttl      = new_ttl;
                    m_data_next.out_checksum = ~fold2;
                end
            end
            CMD_SET, CMD_CLEAR: begin
                m_user_next = VERDICT_TABLE;
            end
            default: begin
                m_user_next = VERDICT_PASS;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            m_user_reg <= m_user_next;
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== sv/ipv4ff_blacklist.sv =====
// Blacklist table of destination addresses with a parallel match on all slots.
`timescale 1ns / 1ps
`default_nettype none

module ipv4ff_blacklist (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire ipv4ff_pkg::tbl_wr_t wr,
    input  wire [31:0]            lookup_addr,
    output logic                  hit
);
    import ipv4ff_pkg::*;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [31:0]              addr_reg [TABLE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (int'(wr.slot) == i) begin
                    valid_reg[i] <= wr.set;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && wr.set) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (int'(wr.slot) == i) begin
                    addr_reg[i] <= wr.address;
                end
            end
        end
    end

    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (valid_reg[i] && (addr_reg[i] == lookup_addr)) begin
                hit = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ipv4ff_checker.sv =====
// Port-level checker of the IPv4 forwarding filter and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_forward_filter_core_defines.svh"

module ipv4ff_checker (
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      s_axis_tvalid,
    input wire                      s_axis_tready,
    input wire ipv4ff_pkg::s_data_t s_axis_tdata,
    input wire [1:0]                s_axis_tuser,
    input wire                      m_axis_tvalid,
    input wire                      m_axis_tready,
    input wire ipv4ff_pkg::m_data_t m_axis_tdata,
    input wire [1:0]                m_axis_tuser
);
    import ipv4ff_pkg::*;

    logic s_acc;
    logic m_stall;
    logic tx_out;
    logic unused_ok;

    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign m_stall   = m_axis_tvalid && !m_axis_tready;
    assign tx_out    = m_axis_tvalid && (m_axis_tuser == VERDICT_TX);
    assign unused_ok = ^{s_axis_tdata, s_axis_tuser};

    // The result register comes out of reset empty.
    `IPV4FF_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_axis_tvalid, "result valid after reset")
    // Input back-pressure only arises behind a waiting result.
    `IPV4FF_ASSERT_SAME(a_stall_cause, aclk, aresetn, !s_axis_tready, m_axis_tvalid, "stall without a pending result")
    // An accepted transaction is followed by a pending result on the output.
    `IPV4FF_ASSERT_NEXT(a_latency, aclk, aresetn, s_acc, ##1 m_axis_tvalid, "result missing after accept")
    // A transmitted header always carries a TTL of at least one.
    `IPV4FF_ASSERT_SAME(a_tx_ttl, aclk, aresetn, tx_out, m_axis_tdata.out_ttl != 8'd0, "transmit with zero TTL")
    // A stalled result transaction stays offered.
    `IPV4FF_ASSERT_NEXT(a_hold, aclk, aresetn, m_stall, m_axis_tvalid, "result withdrawn under stall")

endmodule

bind ipv4_forward_filter_core ipv4ff_checker u_ipv4ff_checker (.*);

`default_nettype wire
